FILE: hdl/rcts_pkg.sv
// Shared constants, types and codes for the raycast column texture shader.
`timescale 1ns / 1ps
`default_nettype none
package rcts_pkg;

    localparam int SCREEN_HEIGHT = 768;
    localparam int TEX_SIZE      = 64;
    localparam int TEX_WIDTH     = 64;
    localparam int WALL_SCALE    = 50;
    localparam int SHADE_CAP     = 200;
    localparam int SHADE_SHIFT   = 24;

    localparam int DIST_W  = 24;
    localparam int COL_W   = 11;
    localparam int ROW_W   = 10;
    localparam int SIDE_W  = 2;
    localparam int TFLD_W  = 6;
    localparam int COLOR_W = 32;
    localparam int SHADE_W = 8;

    localparam int TROW_W = $clog2(TEX_SIZE);
    localparam int TCOL_W = $clog2(TEX_WIDTH);
    localparam int ADDR_W = SIDE_W + TROW_W + TCOL_W;

    localparam int HNUM = SCREEN_HEIGHT * WALL_SCALE * 256;
    localparam int HQ_W = $clog2(HNUM + 1);
    localparam int TQ_W = TROW_W + 1;
    localparam int TN_W = HQ_W + TROW_W;

    localparam logic [HQ_W-1:0] HNUM_V = HQ_W'(HNUM);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_SHADE = 1'b1;

    localparam logic CFG_FLOOR = 1'b0;
    localparam logic CFG_SKY   = 1'b1;

    typedef enum logic [1:0] {
        REGION_FLOOR = 2'd0,
        REGION_WALL  = 2'd1,
        REGION_SKY   = 2'd2
    } region_t;

    typedef struct packed {
        logic               wr;
        logic               live;
        logic [DIST_W-1:0]  ray_dist;
        logic [SIDE_W-1:0]  side;
        logic [TFLD_W-1:0]  tcol;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [TFLD_W-1:0]  trow_w;
        logic [COLOR_W-1:0] data;
    } item_t;

    typedef struct packed {
        item_t   item;
        region_t region;
        logic    hzero;
    } geo_t;

endpackage
`default_nettype wire

FILE: hdl/rcts_hdiv.sv
// Pipelined restoring divider for the wall height, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rcts_hdiv (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire rcts_pkg::item_t            in_item,
    output logic                            out_valid,
    output rcts_pkg::item_t                 out_item,
    output logic [rcts_pkg::HQ_W-1:0]       out_h
);

    localparam int NS = rcts_pkg::HQ_W;
    localparam int DW = rcts_pkg::DIST_W;

    logic            vld_reg [NS];
    rcts_pkg::item_t itm_reg [NS];
    logic [DW-1:0]   rem_reg [NS];
    logic [NS-1:0]   q_reg   [NS];

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic            pv;
        rcts_pkg::item_t pi;
        logic [DW-1:0]   pr;
        logic [NS-1:0]   pq;
        logic [DW:0]     trial;
        logic            take;
        logic [DW-1:0]   rem_next;
        logic [NS-1:0]   q_next;

        if (s == 0) begin : g_first
            assign pv = in_valid;
            assign pi = in_item;
            assign pr = '0;
            assign pq = '0;
        end else begin : g_rest
            assign pv = vld_reg[s-1];
            assign pi = itm_reg[s-1];
            assign pr = rem_reg[s-1];
            assign pq = q_reg[s-1];
        end

        always_comb begin
            trial    = {pr, rcts_pkg::HNUM_V[NS-1-s]};
            take     = trial >= {1'b0, pi.ray_dist};
            rem_next = take ? DW'(trial - {1'b0, pi.ray_dist}) : trial[DW-1:0];
            q_next   = pq;
            q_next[NS-1-s] = take;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= pv;
            end
            if (en) begin
                itm_reg[s] <= pi;
                rem_reg[s] <= rem_next;
                q_reg[s]   <= q_next;
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_item  = itm_reg[NS-1];
    assign out_h     = q_reg[NS-1];

endmodule
`default_nettype wire

FILE: hdl/rcts_tdiv.sv
// Pipelined restoring divider for the texel row, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rcts_tdiv (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire rcts_pkg::geo_t             in_geo,
    input  wire logic [rcts_pkg::HQ_W-1:0]  in_i,
    input  wire logic [rcts_pkg::HQ_W-1:0]  in_h,
    output logic                            out_valid,
    output rcts_pkg::geo_t                  out_geo,
    output logic [rcts_pkg::TQ_W-1:0]       out_q
);

    localparam int NS = rcts_pkg::TQ_W;
    localparam int NW = rcts_pkg::TN_W;
    localparam int HW = rcts_pkg::HQ_W;

    logic           vld_reg [NS];
    rcts_pkg::geo_t geo_reg [NS];
    logic [NW-1:0]  rem_reg [NS];
    logic [HW-1:0]  h_reg   [NS];
    logic [NS-1:0]  q_reg   [NS];

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic           pv;
        rcts_pkg::geo_t pg;
        logic [NW-1:0]  pr;
        logic [HW-1:0]  ph;
        logic [NS-1:0]  pq;
        logic [NW-1:0]  dv;
        logic           take;
        logic [NW-1:0]  rem_next;
        logic [NS-1:0]  q_next;

        if (s == 0) begin : g_first
            assign pv = in_valid;
            assign pg = in_geo;
            assign pr = NW'(in_i) << rcts_pkg::TROW_W;
            assign ph = in_h;
            assign pq = '0;
        end else begin : g_rest
            assign pv = vld_reg[s-1];
            assign pg = geo_reg[s-1];
            assign pr = rem_reg[s-1];
            assign ph = h_reg[s-1];
            assign pq = q_reg[s-1];
        end

        always_comb begin
            dv       = NW'(ph) << (NS - 1 - s);
            take     = pr >= dv;
            rem_next = take ? pr - dv : pr;
            q_next   = pq;
            q_next[NS-1-s] = take;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= pv;
            end
            if (en) begin
                geo_reg[s] <= pg;
                rem_reg[s] <= rem_next;
                h_reg[s]   <= ph;
                q_reg[s]   <= q_next;
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_geo   = geo_reg[NS-1];
    assign out_q     = q_reg[NS-1];

endmodule
`default_nettype wire

FILE: hdl/rcts_tex_mem.sv
// Texture store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rcts_tex_mem (
    input  wire logic                          aclk,
    input  wire logic                          we,
    input  wire logic [rcts_pkg::ADDR_W-1:0]   waddr,
    input  wire logic [rcts_pkg::COLOR_W-1:0]  wdata,
    input  wire logic                          re,
    input  wire logic [rcts_pkg::ADDR_W-1:0]   raddr,
    output logic [rcts_pkg::COLOR_W-1:0]       rdata
);

    logic [rcts_pkg::COLOR_W-1:0] store_mem [2**rcts_pkg::ADDR_W];
    logic [rcts_pkg::COLOR_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: hdl/raycast_column_texture_shader.sv
// Top level of the raycast column texture shader.
`timescale 1ns / 1ps
`default_nettype none
// The shader takes one beat per clock unless the result side stalls it. Each
// shaded pixel passes through the wall height divider, the column geometry
// register, the texel row divider, the texture store read and the output
// register. Texel writes flow down the same pipeline and reach the store in
// order, so a pixel always sees every earlier write. Texel write beats and
// pixels with a row below the screen produce no result. Backpressure on the
// result side stalls the whole pipeline.
module raycast_column_texture_shader (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // distance, side, tex_column, column, row, texel_row, texel_data, zero fill
    input  wire logic [95:0] s_axis_tdata,
    // mode
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_column, out_row, pixel_color, zero fill
    output logic [55:0]      m_axis_tdata,
    // region
    output logic [1:0]       m_axis_tuser,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    localparam int HW = rcts_pkg::HQ_W;
    localparam logic [HW-1:0] HS = HW'(rcts_pkg::SCREEN_HEIGHT);

    logic en;
    logic [31:0] floor_color_reg;
    logic [31:0] sky_color_reg;

    rcts_pkg::item_t in_item;
    logic            h_vld;
    rcts_pkg::item_t h_item;
    logic [HW-1:0]   h_val;

    logic [HW-1:0]   f_w, hp_w, k_w, j_w, i_w;
    logic            is_floor, is_wall;
    rcts_pkg::geo_t  geo_next;

    logic            g_vld_reg;
    rcts_pkg::geo_t  g_geo_reg;
    logic [HW-1:0]   g_i_reg;
    logic [HW-1:0]   g_h_reg;

    logic                          t_vld;
    rcts_pkg::geo_t                t_geo;
    logic [rcts_pkg::TQ_W-1:0]     t_q;
    logic [rcts_pkg::TROW_W-1:0]   trow;
    logic [rcts_pkg::ADDR_W-1:0]   waddr, raddr;
    logic                          mem_we;
    logic [31:0]                   rdata;

    logic [15:0]                   shade_full;
    logic [rcts_pkg::SHADE_W-1:0]  shade_next;

    logic                          p_vld_reg;
    logic                          p_live_reg;
    rcts_pkg::region_t             p_region_reg;
    logic [rcts_pkg::COL_W-1:0]    p_col_reg;
    logic [rcts_pkg::ROW_W-1:0]    p_row_reg;
    logic [rcts_pkg::SHADE_W-1:0]  p_shade_reg;

    logic [31:0]                   color_next;
    logic                          m_tvalid_reg;
    logic [55:0]                   m_tdata_reg;
    logic [1:0]                    m_tuser_reg;

    assign en            = !m_tvalid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_color_reg <= '0;
            sky_color_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rcts_pkg::CFG_FLOOR: floor_color_reg <= cfg_wdata;
                rcts_pkg::CFG_SKY:   sky_color_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_item.wr       = s_axis_tuser == rcts_pkg::MODE_WRITE;
        in_item.live     = (s_axis_tuser == rcts_pkg::MODE_SHADE)
                           && (32'(s_axis_tdata[52:43]) < 32'(rcts_pkg::SCREEN_HEIGHT));
        in_item.ray_dist = (s_axis_tdata[23:0] == '0) ? 24'd1 : s_axis_tdata[23:0];
        in_item.side     = s_axis_tdata[25:24];
        in_item.tcol     = s_axis_tdata[31:26];
        in_item.col      = s_axis_tdata[42:32];
        in_item.row      = s_axis_tdata[52:43];
        in_item.trow_w   = s_axis_tdata[58:53];
        in_item.data     = s_axis_tdata[90:59];
    end

    rcts_hdiv u_hdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_item   (in_item),
        .out_valid (h_vld),
        .out_item  (h_item),
        .out_h     (h_val)
    );

    always_comb begin
        f_w      = (h_val < HS) ? (HS - h_val) >> 1 : '0;
        hp_w     = (h_val > HS) ? h_val - ((h_val - HS) >> 1) : h_val;
        k_w      = HS - HW'(1) - HW'(h_item.row);
        j_w      = k_w - f_w;
        i_w      = hp_w - j_w;
        is_floor = (h_item.row != '0) && (k_w < f_w);
        is_wall  = (h_item.row != '0) && !is_floor && (j_w <= hp_w);
        geo_next.item   = h_item;
        geo_next.hzero  = h_val == '0;
        geo_next.region = is_floor ? rcts_pkg::REGION_FLOOR
                        : (is_wall ? rcts_pkg::REGION_WALL : rcts_pkg::REGION_SKY);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_vld_reg <= 1'b0;
        end else if (en) begin
            g_vld_reg <= h_vld;
        end
        if (en) begin
            g_geo_reg <= geo_next;
            g_i_reg   <= i_w;
            g_h_reg   <= h_val;
        end
    end

    rcts_tdiv u_tdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (g_vld_reg),
        .in_geo    (g_geo_reg),
        .in_i      (g_i_reg),
        .in_h      (g_h_reg),
        .out_valid (t_vld),
        .out_geo   (t_geo),
        .out_q     (t_q)
    );

    always_comb begin
        trow   = t_geo.hzero ? '0 : t_q[rcts_pkg::TROW_W-1:0];
        waddr  = {t_geo.item.side, t_geo.item.trow_w[rcts_pkg::TROW_W-1:0],
                  t_geo.item.tcol[rcts_pkg::TCOL_W-1:0]};
        raddr  = {t_geo.item.side, trow, t_geo.item.tcol[rcts_pkg::TCOL_W-1:0]};
        mem_we = en && t_vld && t_geo.item.wr;
        shade_full = t_geo.item.ray_dist[23:8];
        shade_next = (shade_full > 16'(rcts_pkg::SHADE_CAP))
                   ? rcts_pkg::SHADE_W'(rcts_pkg::SHADE_CAP)
                   : shade_full[rcts_pkg::SHADE_W-1:0];
    end

    rcts_tex_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (t_geo.item.data),
        .re    (en),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
        end else if (en) begin
            p_vld_reg <= t_vld;
        end
        if (en) begin
            p_live_reg   <= t_geo.item.live;
            p_region_reg <= t_geo.region;
            p_col_reg    <= t_geo.item.col;
            p_row_reg    <= t_geo.item.row;
            p_shade_reg  <= shade_next;
        end
    end

    always_comb begin
        case (p_region_reg)
            rcts_pkg::REGION_FLOOR: color_next = floor_color_reg;
            rcts_pkg::REGION_WALL:
                color_next = rdata + (32'(p_shade_reg) << rcts_pkg::SHADE_SHIFT);
            default: color_next = sky_color_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= p_vld_reg && p_live_reg;
        end
        if (en) begin
            m_tdata_reg <= {3'b000, color_next, p_row_reg, p_col_reg};
            m_tuser_reg <= p_region_reg;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

FILE: hdl/rcts_checker.sv
// Port-level checks for the shader and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
module rcts_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result beat right after reset");

    a_region: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser == rcts_pkg::REGION_FLOOR
            || m_axis_tuser == rcts_pkg::REGION_WALL
            || m_axis_tuser == rcts_pkg::REGION_SKY)
        else $error("undefined region code");

    a_top_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[20:11] == '0 |-> m_axis_tuser == rcts_pkg::REGION_SKY)
        else $error("top row is not sky");

    a_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> 32'(m_axis_tdata[20:11]) < 32'(rcts_pkg::SCREEN_HEIGHT))
        else $error("result row below the screen");

endmodule

bind raycast_column_texture_shader rcts_checker u_rcts_checker (.*);
`default_nettype wire

FILE: tb/sv/raycast_column_texture_shader_tb.sv
// Self-checking testbench for the raycast column texture shader: directed and random beats vs a predictor.
`timescale 1ns / 1ps
module raycast_column_texture_shader_tb;

    localparam int  LATENCY   = 40;
    localparam int  CYC_LIMIT = 600000;
    localparam int  STORE_SZ  = 4 * rcts_pkg::TEX_SIZE * rcts_pkg::TEX_WIDTH;
    localparam longint HNUM_L = longint'(rcts_pkg::SCREEN_HEIGHT) * rcts_pkg::WALL_SCALE * 256;

    typedef struct {
        logic        mode;
        logic [23:0] ray_dist;
        logic [1:0]  side;
        logic [5:0]  tcol;
        logic [10:0] col;
        logic [9:0]  row;
        logic [5:0]  trow;
        logic [31:0] data;
    } beat_t;

    typedef struct {
        logic [10:0]       col;
        logic [9:0]        row;
        rcts_pkg::region_t region;
        logic [31:0]       color;
    } pixel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic        cfg_index = rcts_pkg::CFG_FLOOR;
    logic [31:0] cfg_wdata = '0;

    raycast_column_texture_shader u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    beat_t       beat_q[$];
    pixel_t      pixel_q[$];
    beat_t       cur_beat;
    bit          busy = 1'b0;
    bit          hold_tx = 1'b0;
    bit          quiet = 1'b0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          errors = 0;
    int          cycles = 0;
    logic [31:0] floor_word = '0;
    logic [31:0] sky_word = '0;
    logic [31:0] texels [0:STORE_SZ-1];
    bit          texel_set [0:STORE_SZ-1];

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Works out which band of the column a pixel falls in and, for wall
    // pixels, which texel it reads.
    function automatic rcts_pkg::region_t locate(beat_t b, output int addr);
        longint d, h, f, hp, k, i, tr;
        d = (b.ray_dist == 0) ? 1 : b.ray_dist;
        h = HNUM_L / d;
        f = (h < rcts_pkg::SCREEN_HEIGHT) ? (rcts_pkg::SCREEN_HEIGHT - h) / 2 : 0;
        hp = (h > rcts_pkg::SCREEN_HEIGHT) ? h - (h - rcts_pkg::SCREEN_HEIGHT) / 2 : h;
        k = rcts_pkg::SCREEN_HEIGHT - 1 - longint'(b.row);
        addr = 0;
        if (b.row > 0 && k < f) return rcts_pkg::REGION_FLOOR;
        if (b.row > 0 && (k - f) <= hp) begin
            i = hp - (k - f);
            tr = (h == 0) ? 0 : ((rcts_pkg::TEX_SIZE * i) / h) % rcts_pkg::TEX_SIZE;
            addr = int'(b.side) * rcts_pkg::TEX_SIZE * rcts_pkg::TEX_WIDTH
                 + int'(tr) * rcts_pkg::TEX_WIDTH + int'(b.tcol);
            return rcts_pkg::REGION_WALL;
        end
        return rcts_pkg::REGION_SKY;
    endfunction

    task automatic shade_pixel(beat_t b);
        pixel_t p;
        int     addr;
        logic [7:0] shade;
        if (b.mode == rcts_pkg::MODE_WRITE) begin
            texels[{b.side, b.trow, b.tcol}] = b.data;
            return;
        end
        if (b.row >= rcts_pkg::SCREEN_HEIGHT) return;
        p.col = b.col;
        p.row = b.row;
        p.region = locate(b, addr);
        shade = (b.ray_dist[23:8] > rcts_pkg::SHADE_CAP) ? 8'(rcts_pkg::SHADE_CAP)
                                                          : b.ray_dist[15:8];
        case (p.region)
            rcts_pkg::REGION_FLOOR: p.color = floor_word;
            rcts_pkg::REGION_WALL:  p.color = texels[addr] + {shade, 24'd0};
            default:                p.color = sky_word;
        endcase
        pixel_q.push_back(p);
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h, expected %h", what, got, want);
    endtask

    task automatic queue_write(logic [1:0] side, logic [5:0] trow, logic [5:0] tcol,
                               logic [31:0] data);
        beat_t b;
        b = '{rcts_pkg::MODE_WRITE, 24'($urandom), side, tcol, 11'($urandom),
              10'($urandom), trow, data};
        texel_set[{side, trow, tcol}] = 1'b1;
        beat_q.push_back(b);
    endtask

    // A wall pixel whose texel was never loaded gets that texel loaded first.
    task automatic queue_shade(logic [23:0] ray_dist, logic [1:0] side, logic [5:0] tcol,
                               logic [10:0] col, logic [9:0] row);
        beat_t b;
        int    addr;
        b = '{rcts_pkg::MODE_SHADE, ray_dist, side, tcol, col, row, 6'($urandom), $urandom};
        if (row < rcts_pkg::SCREEN_HEIGHT && locate(b, addr) == rcts_pkg::REGION_WALL
            && !texel_set[addr])
            queue_write(addr[13:12], addr[11:6], addr[5:0], $urandom);
        beat_q.push_back(b);
    endtask

    task automatic drain();
        while (beat_q.size() != 0 || busy || pixel_q.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == rcts_pkg::CFG_FLOOR) floor_word = value;
        else sky_word = value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_beats(int n);
        int r;
        logic [23:0] d;
        for (int j = 0; j < n; j++) begin
            if (j == n / 2 && n > 100) begin
                while (beat_q.size() != 0 || busy) @(posedge aclk);
                hold_tx = 1'b1;
                while (pixel_q.size() != 0) @(posedge aclk);
                hold_tx = 1'b0;
            end
            if ($urandom_range(0, 99) < 20) begin
                queue_write(2'($urandom), 6'($urandom), 6'($urandom), $urandom);
            end else begin
                r = $urandom_range(0, 9);
                if (r < 3) d = 24'($urandom_range(1, 12800));
                else if (r < 6) d = 24'($urandom_range(12800, 200000));
                else if (r < 8) d = 24'($urandom);
                else if (r < 9) d = 24'($urandom_range(0, 255));
                else d = 24'($urandom_range(12790, 12810));
                queue_shade(d, 2'($urandom), 6'($urandom), 11'($urandom),
                            ($urandom_range(0, 9) == 0) ? 10'($urandom_range(768, 1023))
                                                        : 10'($urandom_range(0, 767)));
            end
        end
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                shade_pixel(cur_beat);
                busy = 1'b0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pixel_q.size() == 0) begin
                    report("unexpected beat", 32'(m_axis_tdata), 32'd0);
                end else begin
                    pixel_t p;
                    p = pixel_q.pop_front();
                    if (m_axis_tdata[10:0] != p.col)
                        report("column", 32'(m_axis_tdata[10:0]), 32'(p.col));
                    if (m_axis_tdata[20:11] != p.row)
                        report("row", 32'(m_axis_tdata[20:11]), 32'(p.row));
                    if (m_axis_tuser != p.region)
                        report("region", 32'(m_axis_tuser), 32'(p.region));
                    if (m_axis_tdata[52:21] != p.color)
                        report("color", m_axis_tdata[52:21], p.color);
                    if (m_axis_tdata[55:53] != 3'd0)
                        report("fill", 32'(m_axis_tdata[55:53]), 32'd0);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!busy) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (!hold_tx && aresetn && beat_q.size() != 0) begin
                cur_beat = beat_q.pop_front();
                s_axis_tuser <= cur_beat.mode;
                s_axis_tdata <= {5'd0, cur_beat.data, cur_beat.trow, cur_beat.row,
                                 cur_beat.col, cur_beat.tcol, cur_beat.side, cur_beat.ray_dist};
                s_axis_tvalid <= 1'b1;
                busy = 1'b1;
                tx_gap = draw_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_gap = draw_gap();
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_reg(rcts_pkg::CFG_FLOOR, 32'h1122_3344);
        write_reg(rcts_pkg::CFG_SKY, 32'hA5A5_A5A5);
        quiet = 1'b1;
        queue_write(2'd3, 6'd63, 6'd63, 32'hFFFF_FFFF);
        queue_write(2'd0, 6'd0, 6'd0, 32'h0000_0000);
        queue_shade(24'd0, 2'd0, 6'd0, 11'd0, 10'd400);
        queue_shade(24'd1, 2'd3, 6'd63, 11'd2047, 10'd767);
        queue_shade(24'hFFFFFF, 2'd1, 6'd10, 11'd5, 10'd384);
        queue_shade(24'hFFFFFF, 2'd1, 6'd10, 11'd6, 10'd767);
        queue_shade(24'd12800, 2'd2, 6'd33, 11'd7, 10'd1);
        queue_shade(24'd12800, 2'd2, 6'd33, 11'd8, 10'd767);
        queue_shade(24'd12801, 2'd2, 6'd33, 11'd9, 10'd1);
        queue_shade(24'd6400, 2'd1, 6'd2, 11'd10, 10'd0);
        queue_shade(24'd6400, 2'd1, 6'd2, 11'd11, 10'd500);
        queue_shade(24'd51200, 2'd0, 6'd4, 11'd12, 10'd384);
        queue_shade(24'd51456, 2'd0, 6'd4, 11'd13, 10'd384);
        queue_shade(24'd51456, 2'd0, 6'd4, 11'd14, 10'd760);
        queue_shade(24'd51456, 2'd0, 6'd4, 11'd15, 10'd10);
        queue_shade(24'd300, 2'd3, 6'd1, 11'd16, 10'd768);
        queue_shade(24'd300, 2'd3, 6'd1, 11'd17, 10'd1023);
        queue_shade(24'd128, 2'd2, 6'd20, 11'd18, 10'd300);
        drain();
        quiet = 1'b0;

        write_reg(rcts_pkg::CFG_FLOOR, 32'h0000_0000);
        write_reg(rcts_pkg::CFG_SKY, 32'hFFFF_FFFF);
        random_beats(460);
        drain();
        write_reg(rcts_pkg::CFG_FLOOR, 32'hFFFF_FFFF);
        write_reg(rcts_pkg::CFG_SKY, 32'h0000_0000);
        random_beats(460);
        drain();
        write_reg(rcts_pkg::CFG_FLOOR, $urandom);
        write_reg(rcts_pkg::CFG_SKY, $urandom);
        quiet = 1'b1;
        random_beats(300);
        drain();
        quiet = 1'b0;
        write_reg(rcts_pkg::CFG_FLOOR, $urandom);
        write_reg(rcts_pkg::CFG_SKY, $urandom);
        random_beats(460);
        drain();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
